// ----- hdl/mvfr_pkg.sv -----
// Package: payload types and constants for the face velocity reconstruction block.
`timescale 1ns / 1ps
package mvfr_pkg;

  localparam int DepthW = 31;
  localparam int VelW   = 32;
  localparam int MagW   = 33;               // |limited velocity slope| <= 2^32
  localparam int F2W    = 33;               // twice the face depth
  localparam int LoW    = 17;               // low split of f2 for the multiply
  localparam int HiW    = F2W - LoW;
  localparam int ProdW  = MagW + F2W;       // mag * f2
  localparam int QuotW  = 32;               // correction term bits
  localparam int DivW   = DepthW + 2;       // 4 * centre depth

  typedef struct packed {
    logic [DepthW-1:0]       depth_above;
    logic [DepthW-1:0]       depth_centre;
    logic [DepthW-1:0]       depth_below;
    logic signed [VelW-1:0]  vel_above;
    logic signed [VelW-1:0]  vel_centre;
    logic signed [VelW-1:0]  vel_below;
    logic                    left_face;
  } in_word_t;

  typedef struct packed {
    logic signed [VelW-1:0]  vel_face;
    logic                    saturated;
    logic                    zero_depth;
  } out_word_t;

endpackage

// ----- hdl/minmod_velocity_face_reconstruct.sv -----
// Top level: pipelined minmod face velocity reconstruction, one word per cycle unless stalled.
//
// Usage: present one stencil column per cycle on in_data_i with in_valid_i; a word is
// taken at a clock edge with in_valid_i high and in_stall_o low. Results leave on
// out_data_o with out_valid_o, taken when out_stall_i is low.
// Each word yields exactly one result word, in arrival order.
// Throughput: one word per cycle while the output is not held. The pipeline has 37 register
// stages (input register, limiter, multiply, product sum and divider load, 32 divider
// stages, output stage).
// The divider resolves one quotient bit per stage; it sets the pipeline depth.
// The whole pipeline advances together: while out_valid_o is high and out_stall_i
// holds it, every stage holds and in_stall_o is raised, so nothing is lost or
// repeated. Empty stages ahead of a held result do not fill during the stall.
// Reset clears every valid bit; payload registers keep whatever they held.
// A centre depth of zero gives vel_face 0 with zero_depth set.
// Results beyond the signed 32-bit range clip and raise saturated.
`timescale 1ns / 1ps
module minmod_velocity_face_reconstruct (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mvfr_pkg::in_word_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mvfr_pkg::out_word_t   out_data_o
);

  localparam int NDiv = mvfr_pkg::QuotW;
  localparam int MagW = mvfr_pkg::MagW;
  localparam int F2W  = mvfr_pkg::F2W;
  localparam int LoW  = mvfr_pkg::LoW;
  localparam int HiW  = mvfr_pkg::HiW;
  localparam int PW   = mvfr_pkg::ProdW;
  localparam int DW   = mvfr_pkg::DivW;
  localparam int VW   = mvfr_pkg::VelW;

  // advance the whole pipeline unless the output word is held
  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // ---- stage 0: input register
  logic                 v0_q;
  mvfr_pkg::in_word_t   w0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      w0_q <= in_data_i;
    end
  end

  // ---- stage 1: slopes, minmod limiting, twice face depth
  logic signed [32:0] dh1, dh2, mh;
  logic signed [33:0] dv1, dv2, mv;
  logic signed [34:0] f2s;
  logic [F2W-1:0]     f2_d;
  logic [MagW-1:0]    mag_d;

  always_comb begin
    dh1 = $signed({2'b00, w0_q.depth_centre}) - $signed({2'b00, w0_q.depth_below});
    dh2 = $signed({2'b00, w0_q.depth_above}) - $signed({2'b00, w0_q.depth_centre});
    if (dh1 >= 0 && dh2 >= 0) begin
      mh = (dh1 <= dh2) ? dh1 : dh2;
    end else if (dh1 <= 0 && dh2 <= 0) begin
      mh = (dh1 >= dh2) ? dh1 : dh2;
    end else begin
      mh = '0;
    end
    dv1 = 34'(w0_q.vel_centre) - 34'(w0_q.vel_below);
    dv2 = 34'(w0_q.vel_above) - 34'(w0_q.vel_centre);
    if (dv1 >= 0 && dv2 >= 0) begin
      mv = (dv1 <= dv2) ? dv1 : dv2;
    end else if (dv1 <= 0 && dv2 <= 0) begin
      mv = (dv1 >= dv2) ? dv1 : dv2;
    end else begin
      mv = '0;
    end
    f2s = w0_q.left_face ? $signed({3'b000, w0_q.depth_centre, 1'b0}) - 35'(mh)
                         : $signed({3'b000, w0_q.depth_centre, 1'b0}) + 35'(mh);
    f2_d  = (f2s < 0) ? '0 : f2s[F2W-1:0];
    mag_d = mv[33] ? MagW'(-mv) : mv[MagW-1:0];
  end

  logic                   v1_q;
  logic [F2W-1:0]         f2_q;
  logic [MagW-1:0]        mag1_q;
  logic                   neg1_q, zero1_q;
  logic signed [VW-1:0]   vc1_q;
  logic [DW-1:0]          dsr1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      f2_q    <= f2_d;
      mag1_q  <= mag_d;
      neg1_q  <= mv[33];
      zero1_q <= (w0_q.depth_centre == '0);
      vc1_q   <= w0_q.vel_centre;
      dsr1_q  <= {w0_q.depth_centre, 2'b00};
    end
  end

  // ---- stage 2: split multiply mag * f2
  logic                   v2_q;
  logic [MagW+LoW-1:0]    plo_q;
  logic [MagW+HiW-1:0]    phi_q;
  logic                   neg2_q, zero2_q;
  logic signed [VW-1:0]   vc2_q;
  logic [DW-1:0]          dsr2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      plo_q   <= (MagW+LoW)'(mag1_q) * (MagW+LoW)'(f2_q[LoW-1:0]);
      phi_q   <= (MagW+HiW)'(mag1_q) * (MagW+HiW)'(f2_q[F2W-1:LoW]);
      neg2_q  <= neg1_q;
      zero2_q <= zero1_q;
      vc2_q   <= vc1_q;
      dsr2_q  <= dsr1_q;
    end
  end

  // ---- stage 3: sum partial products, load divider
  logic [PW-1:0] prod;
  assign prod = PW'(plo_q) + (PW'(phi_q) << LoW);

  logic                 dv_q   [NDiv+1];
  logic [DW-1:0]        rem_q  [NDiv+1];
  logic [NDiv-1:0]      low_q  [NDiv+1];
  logic [NDiv-1:0]      quo_q  [NDiv+1];
  logic [DW-1:0]        dsr_q  [NDiv+1];
  logic                 neg_q  [NDiv+1];
  logic                 zero_q [NDiv+1];
  logic signed [VW-1:0] vc_q   [NDiv+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0]  <= prod[NDiv+DW-1:NDiv];
      low_q[0]  <= prod[NDiv-1:0];
      quo_q[0]  <= '0;
      dsr_q[0]  <= dsr2_q;
      neg_q[0]  <= neg2_q;
      zero_q[0] <= zero2_q;
      vc_q[0]   <= vc2_q;
    end
  end

  // ---- divider: one restoring step per stage, floor(mag*f2 / (4*hc))
  for (genvar i = 0; i < NDiv; i++) begin : g_div
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_q[i], low_q[i][NDiv-1]};
    assign ge    = (trial >= {1'b0, dsr_q[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i+1] <= 1'b0;
      end else if (adv) begin
        dv_q[i+1] <= dv_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[i+1]  <= ge ? DW'(trial - {1'b0, dsr_q[i]}) : trial[DW-1:0];
        low_q[i+1]  <= {low_q[i][NDiv-2:0], 1'b0};
        quo_q[i+1]  <= {quo_q[i][NDiv-2:0], ge};
        dsr_q[i+1]  <= dsr_q[i];
        neg_q[i+1]  <= neg_q[i];
        zero_q[i+1] <= zero_q[i];
        vc_q[i+1]   <= vc_q[i];
      end
    end
  end

  // ---- output stage: apply correction, saturate
  logic signed [VW+1:0] res;
  mvfr_pkg::out_word_t  out_d;

  always_comb begin
    res = neg_q[NDiv] ? (VW+2)'(vc_q[NDiv]) + $signed({2'b00, quo_q[NDiv]})
                      : (VW+2)'(vc_q[NDiv]) - $signed({2'b00, quo_q[NDiv]});
    out_d.zero_depth = zero_q[NDiv];
    if (zero_q[NDiv]) begin
      out_d.vel_face  = '0;
      out_d.saturated = 1'b0;
    end else if (res > (VW+2)'(32'sh7FFF_FFFF)) begin
      out_d.vel_face  = 32'sh7FFF_FFFF;
      out_d.saturated = 1'b1;
    end else if (res < (VW+2)'(-34'sh8000_0000)) begin
      out_d.vel_face  = 32'sh8000_0000;
      out_d.saturated = 1'b1;
    end else begin
      out_d.vel_face  = res[VW-1:0];
      out_d.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= dv_q[NDiv];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_o <= out_d;
    end
  end

endmodule
